// File: rtl/core/pfpc_pkg.sv
// Package for the purifier flush/produce controller.
// Word types, configuration register indexes and sequencing constants.
// No dependencies.
package pfpc_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_FLUSH_TICKS       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POST_CLOSE_FLUSH_TICKS = 2'd1;

   localparam logic [15:0] AUTO_FLUSH_RESET       = 16'd1000;
   localparam logic [15:0] POST_CLOSE_FLUSH_RESET = 16'd500;

   // sequencing constants, in 20 ms ticks
   localparam logic [9:0]  SELF_TEST_LIMIT     = 10'd900;
   localparam logic [10:0] SHORT_DEBOUNCE      = 11'd250;
   localparam logic [7:0]  CLOSED_DEBOUNCE_MAX = 8'd250;
   localparam logic [10:0] LONG_DEBOUNCE       = 11'd1500;
   localparam logic [15:0] STANDBY_FLUSH       = 16'd500;
   localparam logic [6:0]  RELIEF_TICKS        = 7'd100;
   localparam logic [6:0]  FILL_MAX            = 7'd100;

   typedef struct packed {
      logic self_test_mode;
      logic supply_error;
      logic display_ready;
      logic pressure_switch_open;
   } req_type;

   typedef struct packed {
      logic       flush_valve_on;
      logic       pump_inlet_on;
      logic       producing;
      logic       standby;
      logic [6:0] fill_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] auto_flush_ticks;
      logic [15:0] post_close_flush_ticks;
   } cfg_type;

endpackage

// File: rtl/core/pfpc_csr.sv
// Configuration registers of the purifier flush/produce controller.
// Decodes the write port into the flush length registers; uses pfpc_pkg.
module pfpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pfpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pfpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pfpc_pkg::cfg_type                   cfg
);
   import pfpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_AUTO_FLUSH_TICKS:       cfg_in.auto_flush_ticks       = csr_wdata;
            REG_POST_CLOSE_FLUSH_TICKS: cfg_in.post_close_flush_ticks = csr_wdata;
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_flush_ticks       <= AUTO_FLUSH_RESET;
         cfg_ff.post_close_flush_ticks <= POST_CLOSE_FLUSH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/pfpc_core.sv
// Tick sequencer of the purifier flush/produce controller: timers, flags,
// fill count and the next-state logic for one tick word. Uses pfpc_pkg.
module pfpc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  pfpc_pkg::req_type    item,
   input  pfpc_pkg::cfg_type    cfg,
   output pfpc_pkg::rsp_type    result
);
   import pfpc_pkg::*;

   typedef struct packed {
      logic [9:0]  self_test_timer;
      logic [15:0] flush_timer;
      logic [10:0] open_debounce;
      logic [7:0]  closed_debounce;
      logic [6:0]  relief_timer;
      logic        producing_flag;
      logic        auto_flush_flag;
      logic        standby_flag;
      logic [6:0]  tank_fills;
   } state_type;

   state_type st_ff;
   state_type st_in;

   logic [10:0] self_test_inc;
   logic [11:0] open_inc;
   logic [8:0]  closed_inc;
   logic [6:0]  fills_sat;
   logic        flush_on;
   logic        pump_on;

   assign self_test_inc = {1'b0, st_ff.self_test_timer} + 11'd1;
   assign open_inc      = {1'b0, st_ff.open_debounce} + 12'd1;
   assign closed_inc    = {1'b0, st_ff.closed_debounce} + 9'd1;
   assign fills_sat     = (st_ff.tank_fills < FILL_MAX) ?
                          st_ff.tank_fills + 7'd1 : st_ff.tank_fills;

   always_comb begin
      st_in    = st_ff;
      flush_on = 1'b0;
      pump_on  = 1'b0;
      if (item.self_test_mode) begin
         pump_on = 1'b1;
         if (self_test_inc >= {1'b0, SELF_TEST_LIMIT}) begin
            st_in.self_test_timer = SELF_TEST_LIMIT;
            st_in.producing_flag  = 1'b1;
            st_in.flush_timer     = 16'd0;
         end else begin
            st_in.self_test_timer = self_test_inc[9:0];
            flush_on              = 1'b1;
            st_in.flush_timer     = 16'd1;
         end
      end else if (item.supply_error) begin
         st_in.producing_flag = 1'b0;
         st_in.flush_timer    = 16'd0;
         st_in.open_debounce  = 11'd0;
      end else if (!item.display_ready) begin
         // drives stay off until the display has come up
      end else if (st_ff.flush_timer != 16'd0) begin
         st_in.flush_timer = st_ff.flush_timer - 16'd1;
         if (item.pressure_switch_open) begin
            st_in.closed_debounce = 8'd0;
            if (open_inc >= {1'b0, SHORT_DEBOUNCE}) begin
               st_in.open_debounce  = SHORT_DEBOUNCE;
               st_in.producing_flag = 1'b0;
            end else begin
               st_in.open_debounce = open_inc[10:0];
            end
         end else begin
            st_in.open_debounce = 11'd0;
            if (closed_inc >= {1'b0, CLOSED_DEBOUNCE_MAX})
               st_in.closed_debounce = CLOSED_DEBOUNCE_MAX;
            else
               st_in.closed_debounce = closed_inc[7:0];
         end
         // checks below see the values already updated this tick
         if (st_in.auto_flush_flag && !st_in.producing_flag &&
             st_in.flush_timer == 16'd0 && st_in.open_debounce >= SHORT_DEBOUNCE) begin
            st_in.open_debounce = SHORT_DEBOUNCE;
            st_in.relief_timer  = RELIEF_TICKS;
         end
         if (st_in.closed_debounce >= CLOSED_DEBOUNCE_MAX &&
             st_in.flush_timer == 16'd0 && !st_in.producing_flag) begin
            st_in.flush_timer    = cfg.post_close_flush_ticks;
            st_in.producing_flag = 1'b1;
         end
         if (!st_in.standby_flag && st_in.open_debounce >= SHORT_DEBOUNCE &&
             st_in.flush_timer == 16'd0) begin
            st_in.flush_timer  = cfg.auto_flush_ticks;
            st_in.standby_flag = 1'b1;
            st_in.tank_fills   = fills_sat;
         end
         if (st_in.flush_timer == 16'd0)
            st_in.auto_flush_flag = 1'b0;
         flush_on = 1'b1;
         pump_on  = 1'b1;
      end else if (st_ff.relief_timer != 7'd0) begin
         st_in.relief_timer = st_ff.relief_timer - 7'd1;
         flush_on           = 1'b1;
      end else begin
         if (st_ff.producing_flag) begin
            st_in.standby_flag = 1'b0;
            if (item.pressure_switch_open) begin
               if (open_inc >= {1'b0, LONG_DEBOUNCE}) begin
                  // tank full: count it and start the automatic flush
                  st_in.open_debounce   = 11'd0;
                  st_in.flush_timer     = cfg.auto_flush_ticks;
                  st_in.auto_flush_flag = 1'b1;
                  st_in.standby_flag    = 1'b1;
                  st_in.producing_flag  = 1'b0;
                  st_in.tank_fills      = fills_sat;
               end else begin
                  st_in.open_debounce = open_inc[10:0];
               end
            end else begin
               st_in.open_debounce = 11'd0;
            end
         end else begin
            st_in.standby_flag = 1'b1;
            if (item.pressure_switch_open) begin
               st_in.open_debounce = 11'd0;
            end else if (open_inc >= ((st_ff.tank_fills != 7'd0) ?
                                      {1'b0, LONG_DEBOUNCE} : {1'b0, SHORT_DEBOUNCE})) begin
               // switch stayed closed: flush, then produce again
               st_in.open_debounce   = 11'd0;
               st_in.flush_timer     = STANDBY_FLUSH;
               st_in.auto_flush_flag = 1'b1;
               st_in.producing_flag  = 1'b1;
               st_in.standby_flag    = 1'b0;
            end else begin
               st_in.open_debounce = open_inc[10:0];
            end
         end
         pump_on = st_in.producing_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   assign result.flush_valve_on = flush_on;
   assign result.pump_inlet_on  = pump_on;
   assign result.producing      = st_in.producing_flag;
   assign result.standby        = st_in.standby_flag;
   assign result.fill_count     = st_in.tank_fills;

endmodule

// File: rtl/core/purifier_flush_produce_controller.sv
// Top level of the purifier flush/produce controller: input word register,
// tick sequencer and result register. Uses pfpc_pkg, pfpc_csr, pfpc_core.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  pfpc_pkg::req_type, one tick
//   rsp      out        rsp_valid/rsp_stall  pfpc_pkg::rsp_type, one per tick
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// One tick word per cycle while the result register is not stalled; each tick word
// passes through the input register, then the sequencer into the result register.
// Reset clears all timers, flags and the fill count and loads 1000 and 500
// into the flush length registers.
// rsp_stall holds the result register; req_stall rises only while both the
// input register and the result register are full and the result is stalled.
module purifier_flush_produce_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pfpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pfpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [pfpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pfpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pfpc_pkg::*;

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? fire : rsp_valid_ff;

   pfpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/purifier_flush_produce_controller_tb.sv
// Self-checking testbench for purifier_flush_produce_controller: sends tick words,
// predicts the valve and pump drives, flags and fill count, and checks every result word.
// Depends on pfpc_pkg and the RTL top level only.
module purifier_flush_produce_controller_tb;
   import pfpc_pkg::*;

   // indexes with no register behind them, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int PHASE_TICKS   = 250;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_MAX    = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the controller state and its flush lengths
   logic [15:0] auto_len       = AUTO_FLUSH_RESET;
   logic [15:0] post_len       = POST_CLOSE_FLUSH_RESET;
   logic [9:0]  selftest_ticks = '0;
   logic [15:0] flush_left     = '0;
   logic [10:0] open_count     = '0;
   logic [7:0]  closed_count   = '0;
   logic [6:0]  relief_left    = '0;
   logic        prod_on        = 1'b0;
   logic        autoflush_on   = 1'b0;
   logic        standby_on     = 1'b0;
   logic [6:0]  fills_seen     = '0;

   rsp_type predicted_drives[$];

   int idle_pct      = 10;
   int stall_pct     = 10;
   int noise_pct     = 0;
   int ticks_sent    = 0;
   int words_checked = 0;
   int mismatches    = 0;
   int csr_writes    = 0;

   purifier_flush_produce_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void note_fill();
      if (fills_seen < FILL_MAX) fills_seen = fills_seen + 7'd1;
   endfunction

   function automatic rsp_type predict_valves(req_type w);
      rsp_type     r;
      logic        flush;
      logic        pump;
      logic [10:0] needed;
      flush = 1'b0;
      pump  = 1'b0;
      if (w.self_test_mode) begin
         selftest_ticks = selftest_ticks + 10'd1;
         if (selftest_ticks >= SELF_TEST_LIMIT) begin
            selftest_ticks = SELF_TEST_LIMIT;
            pump       = 1'b1;
            prod_on    = 1'b1;
            flush_left = '0;
         end else begin
            flush      = 1'b1;
            pump       = 1'b1;
            flush_left = 16'd1;
         end
      end else if (w.supply_error) begin
         prod_on    = 1'b0;
         flush_left = '0;
         open_count = '0;
      end else if (!w.display_ready) begin
         // drives stay off until the display is done
      end else if (flush_left != '0) begin
         flush_left = flush_left - 16'd1;
         if (w.pressure_switch_open) begin
            closed_count = '0;
            open_count   = open_count + 11'd1;
            if (open_count >= SHORT_DEBOUNCE) begin
               open_count = SHORT_DEBOUNCE;
               prod_on    = 1'b0;
            end
         end else begin
            open_count   = '0;
            closed_count = closed_count + 8'd1;
            if (closed_count >= CLOSED_DEBOUNCE_MAX) closed_count = CLOSED_DEBOUNCE_MAX;
         end
         if (autoflush_on && !prod_on && flush_left == '0 && open_count >= SHORT_DEBOUNCE) begin
            open_count  = SHORT_DEBOUNCE;
            relief_left = RELIEF_TICKS;
         end
         if (closed_count >= CLOSED_DEBOUNCE_MAX && flush_left == '0 && !prod_on) begin
            flush_left = post_len;
            prod_on    = 1'b1;
         end
         if (!standby_on && open_count >= SHORT_DEBOUNCE && flush_left == '0) begin
            flush_left = auto_len;
            standby_on = 1'b1;
            note_fill();
         end
         if (flush_left == '0) autoflush_on = 1'b0;
         flush = 1'b1;
         pump  = 1'b1;
      end else if (relief_left != '0) begin
         relief_left = relief_left - 7'd1;
         flush       = 1'b1;
      end else begin
         if (prod_on) begin
            standby_on = 1'b0;
            if (w.pressure_switch_open) begin
               open_count = open_count + 11'd1;
               if (open_count >= LONG_DEBOUNCE) begin
                  open_count   = '0;
                  flush_left   = auto_len;
                  autoflush_on = 1'b1;
                  standby_on   = 1'b1;
                  prod_on      = 1'b0;
                  note_fill();
               end
            end else begin
               open_count = '0;
            end
         end else begin
            standby_on = 1'b1;
            if (w.pressure_switch_open) begin
               open_count = '0;
            end else begin
               // restart needs a longer closed spell once the tank has filled
               needed     = (fills_seen >= 7'd1) ? LONG_DEBOUNCE : SHORT_DEBOUNCE;
               open_count = open_count + 11'd1;
               if (open_count >= needed) begin
                  open_count   = '0;
                  flush_left   = STANDBY_FLUSH;
                  autoflush_on = 1'b1;
                  prod_on      = 1'b1;
                  standby_on   = 1'b0;
               end
            end
         end
         pump = prod_on;
      end
      r.flush_valve_on = flush;
      r.pump_inlet_on  = pump;
      r.producing      = prod_on;
      r.standby        = standby_on;
      r.fill_count     = fills_seen;
      return r;
   endfunction

   task automatic flag_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(string what, logic [6:0] want, logic [6:0] got);
      if (got !== want) flag_error($sformatf("%s: expected %0d, got %0d", what, want, got));
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_drives.size() == 0) begin
            flag_error("result word with nothing pending");
         end else begin
            want = predicted_drives.pop_front();
            words_checked++;
            check_field("flush_valve_on", 7'(want.flush_valve_on),
                        7'(rsp_data.flush_valve_on));
            check_field("pump_inlet_on", 7'(want.pump_inlet_on),
                        7'(rsp_data.pump_inlet_on));
            check_field("producing", 7'(want.producing), 7'(rsp_data.producing));
            check_field("standby", 7'(want.standby), 7'(rsp_data.standby));
            check_field("fill_count", want.fill_count, rsp_data.fill_count);
         end
      end
   end

   task automatic send_tick(req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predicted_drives.push_back(predict_valves(w));
      ticks_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (predicted_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      hold_until_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_AUTO_FLUSH_TICKS:       auto_len = value;
         REG_POST_CLOSE_FLUSH_TICKS: post_len = value;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   // normal running word, now and then replaced by an arbitrary one
   function automatic req_type tick_word(logic sw);
      req_type w;
      if ($urandom_range(0, 99) < noise_pct) begin
         w = req_type'(4'($urandom_range(0, 15)));
      end else begin
         w = '{self_test_mode: 1'b0, supply_error: 1'b0, display_ready: 1'b1,
               pressure_switch_open: sw};
      end
      return w;
   endfunction

   task automatic send_run(logic sw, int len);
      for (int i = 0; i < len; i++) send_tick(tick_word(sw));
   endtask

   task automatic test_every_word();
      for (int v = 0; v < 16; v++) send_tick(req_type'(4'(v)));
      // a self-test tick arms a one-tick flush that the next tick runs
      send_tick('{1'b1, 1'b0, 1'b0, 1'b0});
      send_tick(tick_word(1'b1));
      send_tick('{1'b1, 1'b0, 1'b1, 1'b1});
      send_tick(tick_word(1'b0));
   endtask

   // switch runs with lengths clustered around the debounce and flush thresholds;
   // the last run is cut to the budget, and each phase starts the switch in a random state
   task automatic test_random_runs(int budget);
      int   first_tick;
      int   len;
      int   left;
      logic sw;
      first_tick = ticks_sent;
      sw = 1'($urandom_range(0, 1));
      while (ticks_sent - first_tick < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2: len = $urandom_range(1, 20);
            3, 4:    len = $urandom_range(240, 260);
            5:       len = $urandom_range(490, 510);
            default: len = $urandom_range(1490, 1510);
         endcase
         left = budget - (ticks_sent - first_tick);
         if (len > left) len = left;
         if ($urandom_range(0, 4) != 0) sw = ~sw;
         send_run(sw, len);
      end
   endtask

   task automatic test_zero_lengths();
      write_register(REG_AUTO_FLUSH_TICKS, '0);
      write_register(REG_POST_CLOSE_FLUSH_TICKS, '0);
      write_register(REG_SPARE_2, '1);
      write_register(REG_SPARE_3, 16'h5A5A);
      test_random_runs(PHASE_TICKS);
   endtask

   task automatic test_shortest_lengths_steady();
      write_register(REG_AUTO_FLUSH_TICKS, 16'd1);
      write_register(REG_POST_CLOSE_FLUSH_TICKS, 16'd1);
      idle_pct  = 0;
      stall_pct = 0;
      test_random_runs(PHASE_TICKS);
      idle_pct  = 10;
      stall_pct = 10;
   endtask

   // supply-error noise cuts the long flushes short
   task automatic test_longest_lengths();
      write_register(REG_AUTO_FLUSH_TICKS, '1);
      write_register(REG_POST_CLOSE_FLUSH_TICKS, '1);
      noise_pct = 10;
      test_random_runs(PHASE_TICKS);
      noise_pct = 5;
   endtask

   task automatic test_random_lengths();
      write_register(REG_AUTO_FLUSH_TICKS, 16'($urandom_range(1, 1200)));
      write_register(REG_POST_CLOSE_FLUSH_TICKS, 16'($urandom_range(1, 1200)));
      test_random_runs(PHASE_TICKS);
   endtask

   initial begin
      int guard;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_every_word();
      noise_pct = 5;
      test_random_runs(PHASE_TICKS);
      test_zero_lengths();
      test_shortest_lengths_steady();
      test_longest_lengths();
      test_random_lengths();

      req_valid <= 1'b0;
      guard = 0;
      while (predicted_drives.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_drives.size() != 0)
         flag_error($sformatf("%0d result words never arrived", predicted_drives.size()));
      $display("Sent %0d tick words: every input word, then threshold-length switch runs",
               ticks_sent);
      $display("under five flush length setups; checked %0d result words, %0d register writes.",
               words_checked, csr_writes);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
